// ===== rtl/core/quaternion_multiply_normalize_top_macros.svh =====
// assertion macros for the quaternion multiply and normalize block
// used by the top level only; expects clk_i and rst_ni in scope
`ifndef QUATERNION_MULTIPLY_NORMALIZE_TOP_MACROS_SVH
`define QUATERNION_MULTIPLY_NORMALIZE_TOP_MACROS_SVH

// same-cycle implication
`define QMN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qmn assertion failed");

// next-cycle implication
`define QMN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qmn assertion failed");

`endif

// ===== rtl/core/qmn_pkg.sv =====
// shared widths, types and the output saturation function
// no dependencies
package qmn_pkg;

  localparam int CW        = 16;
  localparam int FB        = 14;
  localparam int PRE_SHIFT = (2 * CW > 62) ? (2 * CW - 62) : 0;
  localparam int PW        = 2 * CW;
  localparam int SUM_W     = PW + 2;
  localparam int TOP_W     = 30;
  localparam int EXT_W     = SUM_W + TOP_W;
  localparam int SH_W      = $clog2(EXT_W + 1);
  localparam int SQ_W      = 2 * TOP_W;
  localparam int ACC_W     = SQ_W + 2;
  localparam int TR_W      = ACC_W + 2;
  localparam int ROOT_W    = TOP_W + 1;
  localparam int QW        = FB + 1;
  localparam int NUM_W     = TOP_W + FB + 1;
  localparam int REM_W     = ROOT_W + QW + 1;
  localparam int SAT_W     = QW + CW;

  typedef logic signed [CW-1:0] comp_t;

  typedef struct packed {
    comp_t w;
    comp_t x;
    comp_t y;
    comp_t z;
  } quat_t;

  // pipeline control shared by all stages
  typedef struct packed {
    logic advance;
    logic valid;
  } pipe_ctl_t;

  // per-item side data carried down the pipe
  typedef struct packed {
    logic [3:0]            neg;
    logic                  zero;
    logic [3:0][TOP_W-1:0] mag;
  } lane_t;

  // apply sign and clamp to the signed component range
  function automatic comp_t sat_comp(input logic neg, input logic [QW-1:0] q);
    logic [SAT_W-1:0] maxpos;
    logic [SAT_W-1:0] mag;
    logic [SAT_W-1:0] r;
    maxpos = (SAT_W'(1) << (CW - 1)) - SAT_W'(1);
    mag    = SAT_W'(q);
    if (neg) begin
      if (mag > maxpos + SAT_W'(1)) mag = maxpos + SAT_W'(1);
      r = SAT_W'(0) - mag;
    end else begin
      if (mag > maxpos) mag = maxpos;
      r = mag;
    end
    return comp_t'(r[CW-1:0]);
  endfunction

endpackage

// ===== rtl/core/qmn_product.sv =====
// hamilton product: partial products, then signed row sums
// depends on qmn_pkg
module qmn_product import qmn_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pipe_ctl_t               ctl_i,
  input  quat_t                   a_i,
  input  quat_t                   b_i,
  output logic                    valid_o,
  output logic signed [SUM_W-1:0] p_o [4]
);

  logic signed [PW-1:0]    prod_d [16];
  logic signed [PW-1:0]    prod_q [16];
  logic                    v1_q;
  logic signed [SUM_W-1:0] t    [16];
  logic signed [SUM_W-1:0] p_d  [4];
  logic signed [SUM_W-1:0] p_q  [4];
  logic                    v2_q;

  // sixteen partial products, grouped four per output row
  always_comb begin
    prod_d[0]  = a_i.w * b_i.w;
    prod_d[1]  = a_i.x * b_i.x;
    prod_d[2]  = a_i.y * b_i.y;
    prod_d[3]  = a_i.z * b_i.z;
    prod_d[4]  = a_i.w * b_i.x;
    prod_d[5]  = b_i.w * a_i.x;
    prod_d[6]  = a_i.y * b_i.z;
    prod_d[7]  = a_i.z * b_i.y;
    prod_d[8]  = a_i.w * b_i.y;
    prod_d[9]  = b_i.w * a_i.y;
    prod_d[10] = a_i.z * b_i.x;
    prod_d[11] = a_i.x * b_i.z;
    prod_d[12] = a_i.w * b_i.z;
    prod_d[13] = b_i.w * a_i.z;
    prod_d[14] = a_i.x * b_i.y;
    prod_d[15] = a_i.y * b_i.x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ctl_i.advance) begin
      v1_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      prod_q <= prod_d;
    end
  end

  // floor pre-shift and row sums
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      t[i] = SUM_W'(prod_q[i] >>> PRE_SHIFT);
    end
    p_d[0] = t[0] - t[1] - t[2] - t[3];
    p_d[1] = t[4] + t[5] + t[6] - t[7];
    p_d[2] = t[8] + t[9] + t[10] - t[11];
    p_d[3] = t[12] + t[13] + t[14] - t[15];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ctl_i.advance) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      p_q <= p_d;
    end
  end

  assign valid_o = v2_q;
  assign p_o     = p_q;

endmodule

// ===== rtl/core/qmn_scale.sv =====
// magnitudes, block scaling to 30 bits, squares and their sum
// depends on qmn_pkg
module qmn_scale import qmn_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pipe_ctl_t               ctl_i,
  input  logic signed [SUM_W-1:0] p_i [4],
  output logic                    valid_o,
  output lane_t                   lane_o,
  output logic [ACC_W-1:0]        acc_o
);

  logic [4:0]             v_q;
  logic [SUM_W-1:0]       mag_d  [4];
  logic [SUM_W-1:0]       mag3_q [4];
  logic [SUM_W-1:0]       mag4_q [4];
  logic [3:0]             neg3_q, neg4_q;
  logic [SUM_W-1:0]       orm_d, orm_q;
  logic [SH_W-1:0]        shamt_d, shamt_q;
  logic                   zero4_q;
  lane_t                  lane_d, lane5_q, lane6_q, lane7_q;
  logic [SQ_W-1:0]        sq_d [4];
  logic [SQ_W-1:0]        sq_q [4];
  logic [ACC_W-1:0]       acc_d, acc_q;
  logic [EXT_W-1:0]       ext;

  // pipeline valid bits, one per register stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (ctl_i.advance) begin
      v_q <= {v_q[3:0], ctl_i.valid};
    end
  end

  // absolute values and combined bit pattern
  always_comb begin
    orm_d = '0;
    for (int i = 0; i < 4; i++) begin
      mag_d[i] = p_i[i][SUM_W-1] ? SUM_W'(-p_i[i]) : SUM_W'(p_i[i]);
      orm_d    = orm_d | mag_d[i];
    end
  end

  // left shift amount from the bit length of the largest magnitude
  always_comb begin
    shamt_d = SH_W'(EXT_W);
    for (int i = 0; i < SUM_W; i++) begin
      if (orm_q[i]) shamt_d = SH_W'(EXT_W - i - 1);
    end
  end

  // left-justify and keep the top bits
  always_comb begin
    lane_d.neg  = neg4_q;
    lane_d.zero = zero4_q;
    for (int i = 0; i < 4; i++) begin
      ext           = EXT_W'(mag4_q[i]) << shamt_q;
      lane_d.mag[i] = ext[EXT_W-1 -: TOP_W];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq_d[i] = SQ_W'(lane5_q.mag[i]) * SQ_W'(lane5_q.mag[i]);
    end
    acc_d = ACC_W'(sq_q[0]) + ACC_W'(sq_q[1]) + ACC_W'(sq_q[2]) + ACC_W'(sq_q[3]);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      for (int i = 0; i < 4; i++) begin
        neg3_q[i] <= p_i[i][SUM_W-1];
      end
      mag3_q  <= mag_d;
      orm_q   <= orm_d;
      mag4_q  <= mag3_q;
      neg4_q  <= neg3_q;
      zero4_q <= (orm_q == '0);
      shamt_q <= shamt_d;
      lane5_q <= lane_d;
      sq_q    <= sq_d;
      lane6_q <= lane5_q;
      acc_q   <= acc_d;
      lane7_q <= lane6_q;
    end
  end

  assign valid_o = v_q[4];
  assign lane_o  = lane7_q;
  assign acc_o   = acc_q;

endmodule

// ===== rtl/core/qmn_sqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on qmn_pkg
module qmn_sqrt import qmn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pipe_ctl_t         ctl_i,
  input  lane_t             lane_i,
  input  logic [ACC_W-1:0]  acc_i,
  output logic              valid_o,
  output lane_t             lane_o,
  output logic [ROOT_W-1:0] root_o
);

  logic              v_q    [ROOT_W];
  logic [ACC_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  lane_t             lane_q [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int K = ROOT_W - 1 - s;
    logic              vin;
    logic [ACC_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    lane_t             lane_in;
    logic [TR_W-1:0]   trial;
    logic              take;

    if (s == 0) begin : g_first
      assign vin     = ctl_i.valid;
      assign rem_in  = acc_i;
      assign root_in = '0;
      assign lane_in = lane_i;
    end else begin : g_next
      assign vin     = v_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign lane_in = lane_q[s-1];
    end

    // trial subtract of (2r + 2^k) * 2^k
    assign trial = (TR_W'(root_in) << (K + 1)) | (TR_W'(1) << (2 * K));
    assign take  = TR_W'(rem_in) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (ctl_i.advance) begin
        v_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.advance) begin
        rem_q[s]  <= take ? ACC_W'(TR_W'(rem_in) - trial) : rem_in;
        root_q[s] <= take ? (root_in | (ROOT_W'(1) << K)) : root_in;
        lane_q[s] <= lane_in;
      end
    end
  end

  assign valid_o = v_q[ROOT_W-1];
  assign lane_o  = lane_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];

endmodule

// ===== rtl/core/qmn_div.sv =====
// rounded division of each magnitude by the length, restoring, one bit per stage
// depends on qmn_pkg
module qmn_div import qmn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pipe_ctl_t         ctl_i,
  input  lane_t             lane_i,
  input  logic [ROOT_W-1:0] len_i,
  output logic              valid_o,
  output logic [3:0]        neg_o,
  output logic              zero_o,
  output logic [QW-1:0]     q_o [4]
);

  typedef struct packed {
    logic [3:0]            neg;
    logic                  zero;
    logic [ROOT_W-1:0]     len;
    logic [3:0][REM_W-1:0] rem;
    logic [3:0][QW-1:0]    q;
  } div_lane_t;

  localparam int NST = QW + 1;

  logic      v_q  [NST];
  div_lane_t dl_q [NST];
  div_lane_t dl0_d;

  // rounded numerator: (mag << FB) + len / 2
  always_comb begin
    dl0_d.neg  = lane_i.neg;
    dl0_d.zero = lane_i.zero;
    dl0_d.len  = len_i;
    dl0_d.q    = '0;
    for (int i = 0; i < 4; i++) begin
      dl0_d.rem[i] = REM_W'((NUM_W'(lane_i.mag[i]) << FB) + NUM_W'(len_i >> 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (ctl_i.advance) begin
      v_q[0] <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      dl_q[0] <= dl0_d;
    end
  end

  for (genvar s = 1; s < NST; s++) begin : g_stage
    localparam int J = QW - s;
    div_lane_t        dl_d;
    logic [REM_W-1:0] dd;

    assign dd = REM_W'(dl_q[s-1].len) << J;

    always_comb begin
      dl_d = dl_q[s-1];
      for (int i = 0; i < 4; i++) begin
        if (dl_q[s-1].rem[i] >= dd) begin
          dl_d.rem[i] = dl_q[s-1].rem[i] - dd;
          dl_d.q[i]   = dl_q[s-1].q[i] | (QW'(1) << J);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (ctl_i.advance) begin
        v_q[s] <= v_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.advance) begin
        dl_q[s] <= dl_d;
      end
    end
  end

  assign valid_o = v_q[NST-1];
  assign neg_o   = dl_q[NST-1].neg;
  assign zero_o  = dl_q[NST-1].zero;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      q_o[i] = dl_q[NST-1].q[i];
    end
  end

endmodule

// ===== rtl/core/quaternion_multiply_normalize_top.sv =====
// channel   dir  beat payload
// s_axis    in   tdata: left w,x,y,z then right w,x,y,z, 16 bits each
// m_axis    out  tdata: product w,x,y,z, 16 bits each; tuser: zero_length
//
// the pipe runs through product, scaling, square root, divide and output register stages in that order
// one beat enters every cycle while the output beat is not held; the whole pipe moves on one shared advance enable
// a stalled output freezes every stage, so nothing is dropped or repeated
// reset clears the valid bits only
// top level: depends on qmn_pkg, qmn_product, qmn_scale, qmn_sqrt, qmn_div
`include "quaternion_multiply_normalize_top_macros.svh"
module quaternion_multiply_normalize_top import qmn_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  // left_scalar, left_vec_x, left_vec_y, left_vec_z,
  // right_scalar, right_vec_x, right_vec_y, right_vec_z
  input  logic [8*CW-1:0] s_axis_tdata,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  // prod_scalar, prod_vec_x, prod_vec_y, prod_vec_z
  output logic [4*CW-1:0] m_axis_tdata,
  // zero_length
  output logic           m_axis_tuser
);

  pipe_ctl_t               ctl_in, ctl_prod, ctl_scale, ctl_sqrt;
  quat_t                   qa, qb;
  logic                    prod_valid, scale_valid, sqrt_valid, div_valid;
  logic signed [SUM_W-1:0] p [4];
  lane_t                   scale_lane, sqrt_lane;
  logic [ACC_W-1:0]        acc;
  logic [ROOT_W-1:0]       len;
  logic [3:0]              div_neg;
  logic                    div_zero;
  logic [QW-1:0]           div_q [4];
  logic                    out_valid_q;
  logic [4*CW-1:0]         out_data_d, out_data_q;
  logic                    out_zero_q;
  logic                    advance;

  // whole pipe moves unless the output beat is held
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;

  // unpack input beat, first field lowest
  assign qa.w = comp_t'(s_axis_tdata[0*CW +: CW]);
  assign qa.x = comp_t'(s_axis_tdata[1*CW +: CW]);
  assign qa.y = comp_t'(s_axis_tdata[2*CW +: CW]);
  assign qa.z = comp_t'(s_axis_tdata[3*CW +: CW]);
  assign qb.w = comp_t'(s_axis_tdata[4*CW +: CW]);
  assign qb.x = comp_t'(s_axis_tdata[5*CW +: CW]);
  assign qb.y = comp_t'(s_axis_tdata[6*CW +: CW]);
  assign qb.z = comp_t'(s_axis_tdata[7*CW +: CW]);

  assign ctl_in    = '{advance: advance, valid: s_axis_tvalid};
  assign ctl_prod  = '{advance: advance, valid: prod_valid};
  assign ctl_scale = '{advance: advance, valid: scale_valid};
  assign ctl_sqrt  = '{advance: advance, valid: sqrt_valid};

  qmn_product u_product (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_in),
    .a_i     (qa),
    .b_i     (qb),
    .valid_o (prod_valid),
    .p_o     (p)
  );

  qmn_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_prod),
    .p_i     (p),
    .valid_o (scale_valid),
    .lane_o  (scale_lane),
    .acc_o   (acc)
  );

  qmn_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_scale),
    .lane_i  (scale_lane),
    .acc_i   (acc),
    .valid_o (sqrt_valid),
    .lane_o  (sqrt_lane),
    .root_o  (len)
  );

  qmn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_sqrt),
    .lane_i  (sqrt_lane),
    .len_i   (len),
    .valid_o (div_valid),
    .neg_o   (div_neg),
    .zero_o  (div_zero),
    .q_o     (div_q)
  );

  // sign, saturation and zero-length override
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      out_data_d[(3-i)*CW +: CW] = div_zero ? '0 : sat_comp(div_neg[3-i], div_q[3-i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
      out_zero_q <= div_zero;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_zero_q;

  // a zero-length result carries an all-zero product
  `QMN_ASSERT_IMP(a_zero_data, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
  // a normalized result always has a nonzero component
  `QMN_ASSERT_IMP(a_norm_nonzero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata != '0)
  // a held output beat stalls the input side in the same cycle
  `QMN_ASSERT_IMP(a_stall_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  // a held output beat stays valid and unchanged
  `QMN_ASSERT_NXT(a_hold_output, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule
